>>> rtl/core/btlp_pkg.sv
package btlp_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd5000;
  localparam logic [CFG_W-1:0] BLINK_RST    = 16'd1000;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 2'd2;

  // mode codes as seen on the result word
  localparam logic [MODE_W-1:0] MODE_CODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_BLINK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_WAIT   = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_BLINK  = 3'b010,
    MODE_WAIT   = 3'b100
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] blink_ticks;
  } cfg_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_BLINK: c = MODE_CODE_BLINK;
      MODE_WAIT:  c = MODE_CODE_WAIT;
      default:    c = MODE_CODE_NORMAL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/btlp_cfg_regs.sv
module btlp_cfg_regs
  import btlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_RST;
      cfg_r.blink_ticks      <= BLINK_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks   <= wr_data;
        REG_LONG:     cfg_r.long_press_ticks <= wr_data;
        REG_BLINK:    cfg_r.blink_ticks      <= wr_data;
        default:      ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/btlp_step.sv
module btlp_step
  import btlp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   lvl,
  input  cfg_t                   cfg,
  input  mode_t                  mode,
  input  logic                   last_raw,
  input  logic                   deb,
  input  logic                   led,
  input  logic [COUNT_WIDTH-1:0] stable_cnt,
  input  logic [COUNT_WIDTH-1:0] blink_cnt,
  input  logic                   prev_lvl,
  output mode_t                  mode_nxt,
  output logic                   last_raw_nxt,
  output logic                   deb_nxt,
  output logic                   led_nxt,
  output logic [COUNT_WIDTH-1:0] stable_cnt_nxt,
  output logic [COUNT_WIDTH-1:0] blink_cnt_nxt,
  output logic                   prev_lvl_nxt
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] sc_new;
  logic [COUNT_WIDTH-1:0] bc_inc;
  logic                   deb_new;
  logic                   led_new;
  logic                   over_debounce;
  logic                   over_long;
  logic                   blink_hit;
  logic                   entry_hit;

  always_comb begin
    if (lvl != last_raw) begin
      sc_new = '0;
    end else if (stable_cnt == CNT_MAX) begin
      sc_new = CNT_MAX;
    end else begin
      sc_new = stable_cnt + 1'b1;
    end
    over_debounce = CMP_W'(sc_new) > CMP_W'(cfg.debounce_ticks);
    over_long     = CMP_W'(sc_new) > CMP_W'(cfg.long_press_ticks);
    // accepted press toggles the LED
    deb_new = deb;
    led_new = led;
    if (over_debounce && (lvl != deb)) begin
      deb_new = lvl;
      if (lvl) led_new = ~led;
    end
    bc_inc    = (blink_cnt == CNT_MAX) ? CNT_MAX : blink_cnt + 1'b1;
    blink_hit = CMP_W'(bc_inc) >= CMP_W'(cfg.blink_ticks);
    // on entry the counter starts saturated, so it stays at max
    entry_hit = CMP_W'(CNT_MAX) >= CMP_W'(cfg.blink_ticks);
  end

  always_comb begin
    mode_nxt       = mode;
    last_raw_nxt   = last_raw;
    deb_nxt        = deb;
    led_nxt        = led;
    stable_cnt_nxt = stable_cnt;
    blink_cnt_nxt  = blink_cnt;
    prev_lvl_nxt   = prev_lvl;
    unique case (mode)
      MODE_BLINK: begin
        prev_lvl_nxt = lvl;
        if (lvl && !prev_lvl) begin
          led_nxt        = 1'b1;
          stable_cnt_nxt = '0;
          mode_nxt       = MODE_WAIT;
        end else if (blink_hit) begin
          led_nxt       = ~led;
          blink_cnt_nxt = '0;
        end else begin
          blink_cnt_nxt = bc_inc;
        end
      end
      MODE_WAIT: begin
        if (!lvl) mode_nxt = MODE_NORMAL;
      end
      default: begin
        mode_nxt       = MODE_NORMAL;
        last_raw_nxt   = lvl;
        stable_cnt_nxt = sc_new;
        deb_nxt        = deb_new;
        led_nxt        = led_new;
        if (lvl && deb_new && over_long) begin
          mode_nxt     = MODE_BLINK;
          prev_lvl_nxt = lvl;
          if (entry_hit) begin
            led_nxt       = ~led_new;
            blink_cnt_nxt = '0;
          end else begin
            blink_cnt_nxt = CNT_MAX;
          end
        end
      end
    endcase
  end

endmodule

>>> rtl/core/button_toggle_long_press_blink.sv
// Debounced button LED toggle with long-press blink mode.
// Input channel: one word per millisecond tick, in_button_level is the raw
// sample. Accepted when in_valid is high and in_stall is low.
// Result channel: one word per input word, out_led_on and out_mode
// (0 normal, 1 blinking, 2 waiting for release). Taken when out_valid is
// high and out_stall is low.
// Config channel: cfg_index selects debounce, long-press or blink period;
// cfg_ready is always high, indexes beyond the list are dropped.
// The result of a word sits in the output register on the cycle after
// acceptance. The block takes one word per cycle while in_stall is low;
// the state update feeding the output register is combinational.
// A stalled result holds; in_stall rises only while a result is held, so
// the block takes a new word in the same cycle the old result leaves.
// Reset (synchronous, rst_n low) loads the default periods, normal mode, LED
// lit, and empties the output register.
module button_toggle_long_press_blink
  import btlp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_button_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_led_on,
  output logic [MODE_W-1:0]    out_mode,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;

  mode_t                  mode_r, mode_nxt;
  logic                   last_raw_r, last_raw_nxt;
  logic                   deb_r, deb_nxt;
  logic                   led_r, led_nxt;
  logic [COUNT_WIDTH-1:0] stable_cnt_r, stable_cnt_nxt;
  logic [COUNT_WIDTH-1:0] blink_cnt_r, blink_cnt_nxt;
  logic                   prev_lvl_r, prev_lvl_nxt;

  logic                   out_valid_r;
  logic                   out_led_r;
  logic [MODE_W-1:0]      out_mode_r;
  logic                   in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;

  btlp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  btlp_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .lvl            (in_button_level),
    .cfg            (cfg),
    .mode           (mode_r),
    .last_raw       (last_raw_r),
    .deb            (deb_r),
    .led            (led_r),
    .stable_cnt     (stable_cnt_r),
    .blink_cnt      (blink_cnt_r),
    .prev_lvl       (prev_lvl_r),
    .mode_nxt       (mode_nxt),
    .last_raw_nxt   (last_raw_nxt),
    .deb_nxt        (deb_nxt),
    .led_nxt        (led_nxt),
    .stable_cnt_nxt (stable_cnt_nxt),
    .blink_cnt_nxt  (blink_cnt_nxt),
    .prev_lvl_nxt   (prev_lvl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      last_raw_r   <= 1'b0;
      deb_r        <= 1'b0;
      led_r        <= 1'b1;
      stable_cnt_r <= '0;
      blink_cnt_r  <= '1;
    end else if (in_take) begin
      mode_r       <= mode_nxt;
      last_raw_r   <= last_raw_nxt;
      deb_r        <= deb_nxt;
      led_r        <= led_nxt;
      stable_cnt_r <= stable_cnt_nxt;
      blink_cnt_r  <= blink_cnt_nxt;
    end
  end

  // only read in blink mode, always written on entry
  always_ff @(posedge clk) begin
    if (in_take) prev_lvl_r <= prev_lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_led_r  <= led_nxt;
      out_mode_r <= mode_code(mode_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_led_on = out_led_r;
  assign out_mode   = out_mode_r;

endmodule

>>> rtl/core/btlp_checker.sv
module btlp_checker
  import btlp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_led_on,
  input logic [MODE_W-1:0]    out_mode
);

  // unused mode code never shows on a result
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode != 2'd3))
    else $error("out_mode carries unused code");

  // every accepted word yields a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("result missing after accepted word");

  // input backs up only while a result is held by the receiver
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without held result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_led_on) && $stable(out_mode)))
    else $error("stalled result changed");

endmodule

bind button_toggle_long_press_blink btlp_checker u_btlp_checker (.*);

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btlp_pkg::*;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [1:0] PREV_NONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LIMIT = 400000;
  localparam int HOLD_LEN = 80;

  typedef struct packed {
    logic              led;
    logic [MODE_W-1:0] mode;
  } led_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_button_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_led_on;
  logic [MODE_W-1:0]    out_mode;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  bit        tick_q[$];
  led_word_t led_q[$];
  cfg_word_t cfg_q[$];
  bit        quiet = 1'b0;
  bit        long_hold_req = 1'b0;
  bit        last_pushed = 1'b0;
  int        err_cnt = 0;
  int        cyc = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_cnt = 0;
  led_word_t want_word;
  cfg_word_t next_cfg;

  // local copy of the block's registers and state
  logic [CFG_W-1:0]  deb_cfg, long_cfg, blink_cfg;
  logic              raw_prev, deb_lvl, led_lvl;
  logic [CNT_W-1:0]  stable_cnt, blink_cnt;
  logic [MODE_W-1:0] mode_now;
  logic [1:0]        prev_sample;

  button_toggle_long_press_blink #(.COUNT_WIDTH(CNT_W)) DUT (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 1);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (err_cnt < 100) $display("mismatch: %s got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  task automatic blink_advance();
    blink_cnt = sat_up(blink_cnt);
    if (blink_cnt >= blink_cfg) begin
      led_lvl = ~led_lvl;
      blink_cnt = '0;
    end
  endtask

  task automatic advance_tick(logic lvl);
    case (mode_now)
      MODE_CODE_BLINK: begin
        if (lvl && prev_sample == 2'd0) begin
          led_lvl = 1'b1;
          stable_cnt = '0;
          mode_now = MODE_CODE_WAIT;
        end else begin
          blink_advance();
        end
        prev_sample = {1'b0, lvl};
      end
      MODE_CODE_WAIT: begin
        if (!lvl) mode_now = MODE_CODE_NORMAL;
      end
      default: begin
        mode_now = MODE_CODE_NORMAL;
        stable_cnt = (lvl != raw_prev) ? '0 : sat_up(stable_cnt);
        raw_prev = lvl;
        if (stable_cnt > deb_cfg && lvl != deb_lvl) begin
          deb_lvl = lvl;
          if (lvl) led_lvl = ~led_lvl;
        end
        // long press is judged after the debounce update of the same tick
        if (lvl && deb_lvl && stable_cnt > long_cfg) begin
          mode_now = MODE_CODE_BLINK;
          blink_cnt = CNT_MAX;
          blink_advance();
          prev_sample = {1'b0, lvl};
        end
      end
    endcase
    led_q.push_back('{led: led_lvl, mode: mode_now});
  endtask

  task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_DEBOUNCE: deb_cfg = data;
      REG_LONG:     long_cfg = data;
      REG_BLINK:    blink_cfg = data;
      default: ;
    endcase
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_tick(in_button_level);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (tick_q.size() != 0) begin
          in_valid <= 1'b1;
          in_button_level <= tick_q.pop_front();
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off length
  always @(posedge clk) begin
    if (long_hold_req && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (led_q.size() == 0) begin
          flag_mismatch("result word with nothing pending", out_mode, 0);
        end else begin
          want_word = led_q.pop_front();
          if (out_led_on !== want_word.led)
            flag_mismatch("led_on", out_led_on, want_word.led);
          if (out_mode !== want_word.mode)
            flag_mismatch("mode", out_mode, want_word.mode);
        end
        out_gap = pick_gap();
      end
      if (long_hold_req && hold_cnt < HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // register writer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() != 0) begin
          next_cfg = cfg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_cfg.idx;
          cfg_data <= next_cfg.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic settle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || led_q.size() != 0 ||
           cfg_q.size() != 0 || cfg_valid);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_cfg(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng,
                         logic [CFG_W-1:0] blk);
    cfg_q.push_back('{idx: REG_SPARE, data: 16'($urandom)});
    cfg_q.push_back('{idx: REG_DEBOUNCE, data: deb});
    cfg_q.push_back('{idx: REG_LONG, data: lng});
    cfg_q.push_back('{idx: REG_BLINK, data: blk});
    settle();
  endtask

  task automatic push_level(bit lvl, int n);
    repeat (n) tick_q.push_back(lvl);
    last_pushed = lvl;
  endtask

  // mostly clean press/release runs, some single-tick bounces
  task automatic press_traffic(int n);
    int left, len, cap;
    bit lvl;
    left = n;
    lvl = last_pushed;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        lvl = $urandom_range(0, 1);
        len = 1;
      end else begin
        lvl = ~lvl;
        cap = int'(deb_cfg) + int'(long_cfg) + 3 * int'(blink_cfg) + 6;
        if (cap > 60) cap = 60;
        len = $urandom_range(1, cap);
      end
      if (len > left) len = left;
      push_level(lvl, len);
      left -= len;
    end
  endtask

  initial begin
    deb_cfg = DEBOUNCE_RST;
    long_cfg = LONG_RST;
    blink_cfg = BLINK_RST;
    raw_prev = 1'b0;
    deb_lvl = 1'b0;
    led_lvl = 1'b1;
    stable_cnt = '0;
    mode_now = MODE_CODE_NORMAL;
    blink_cnt = CNT_MAX;
    prev_sample = PREV_NONE;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset periods: nothing settles this soon
    push_level(1'b1, 3);
    push_level(1'b0, 2);
    settle();

    // no debounce, zero blink period: toggle every blink tick
    set_cfg(16'd0, 16'd3, 16'd0);
    push_level(1'b1, 7);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    push_level(1'b0, 2);
    settle();

    // zero long press: blink entry on the debounce tick itself
    set_cfg(16'd2, 16'd0, 16'd2);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 6);
    push_level(1'b0, 1);
    push_level(1'b1, 1);
    push_level(1'b0, 2);
    settle();

    // debounce threshold at the counter limit is never passed
    set_cfg(16'hFFFF, 16'd0, 16'd1);
    press_traffic(20);
    settle();

    // one long steady press runs into blink mode, then release
    quiet = 1'b1;
    set_cfg(16'd20, 16'd40, 16'd5);
    push_level(1'b1, 60);
    push_level(1'b0, 3);
    settle();

    // receiver holds off while words keep coming
    set_cfg(16'd1, 16'd6, 16'd1);
    long_hold_req = 1'b1;
    press_traffic(150);
    settle();
    quiet = 1'b0;

    repeat (9) begin
      case ($urandom_range(0, 5))
        0: set_cfg(16'($urandom), 16'($urandom), 16'($urandom));
        1: set_cfg(16'd0, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 1)));
        default: set_cfg(16'($urandom_range(0, 4)), 16'($urandom_range(0, 25)),
                         16'($urandom_range(0, 8)));
      endcase
      press_traffic(70);
      settle();
    end

    repeat (4) @(negedge clk);
    if (led_q.size() != 0) flag_mismatch("result words missing", 0, led_q.size());
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
